### rtl/lrp_pkg.sv
`timescale 1ns / 1ps

package lrp_pkg;

    // defaults handed to the top-level parameters
    localparam int LRP_FRAMES_DEF = 8;
    localparam int LRP_PAGES_DEF  = 16;

    // frames_in_use register
    localparam int                CFG_W     = 4;
    localparam logic [CFG_W-1:0]  CFG_RESET = 4'd8;

    localparam int FAULT_W = 32;

    // controller to datapath
    typedef struct packed {
        logic take;     // latch the incoming page
        logic find;     // hit search and victim choice
        logic commit;   // frame update and result load
    } t_lrp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;   // result register holds an item
        logic out_taken;  // that item leaves this cycle
    } t_lrp_sts;

endpackage

### rtl/lrp_req_if.sv
`timescale 1ns / 1ps

interface lrp_req_if #(
    parameter int PAGE_W = 4
);
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

### rtl/lrp_rsp_if.sv
`timescale 1ns / 1ps

interface lrp_rsp_if #(
    parameter int PAGE_W  = 4,
    parameter int SLOT_W  = 3,
    parameter int FAULT_W = 32
);
    logic               valid;
    logic               ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;

    modport source (output valid, output hit, output slot, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input slot, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

### rtl/lru_page_replacement.sv
`timescale 1ns / 1ps

// lru page replacement engine
// i_req carries one page reference per item (valid/ready, page). o_rsp
// returns one result per reference: hit, the frame slot that holds the
// page afterwards, the evicted page if any, and the saturating fault count.
// i_cfg_we/i_cfg_wdata write frames_in_use (0 acts as 1, above FRAMES acts
// as FRAMES); write it only while no reference is in flight.
// an accepted reference is latched, then its lookup and victim choice are
// registered, then its commit loads the result register once that is free.
// a new reference is taken only after the last one commits; take, lookup
// with victim choice, and frame update are steps over the shared frame table.
// i_req.ready is high only while the controller waits for a reference,
// independent of o_rsp, so a new reference goes in while a result waits.
// when o_rsp stalls, the next reference parks after its victim choice and
// commits in the cycle that the pending result is taken.
// reset (synchronous, active low): all frames empty, fault count zero,
// frames_in_use back to 8 (or FRAMES if smaller), no result pending.

module lru_page_replacement
    import lrp_pkg::*;
#(
    parameter int FRAMES = LRP_FRAMES_DEF,
    parameter int PAGES  = LRP_PAGES_DEF
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lrp_req_if.sink          i_req,
    lrp_rsp_if.source        o_rsp
);

    // command and status between the sequencer and the frame table
    t_lrp_cmd cmd;
    t_lrp_sts sts;

    // three-step sequencer: wait, find, commit
    lrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // frame table, ranks, counters and the result register
    lrp_dp #(
        .FRAMES (FRAMES),
        .PAGES  (PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_page      (i_req.page),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

endmodule

### rtl/lrp_ctrl.sv
`timescale 1ns / 1ps

module lrp_ctrl
    import lrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_lrp_sts i_sts,
    output t_lrp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FIND   = 3'b010,
        ST_COMMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   commit_ok;

    assign commit_ok = !i_sts.out_full || i_sts.out_taken;

    always_comb begin
        n_state      = r_state;
        o_req_ready  = 1'b0;
        o_cmd.take   = 1'b0;
        o_cmd.find   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_FIND;
                end
            end
            ST_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = ST_COMMIT;
            end
            ST_COMMIT: begin
                // hold here while the previous result is still unread
                if (commit_ok) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/lrp_dp.sv
`timescale 1ns / 1ps

module lrp_dp
    import lrp_pkg::*;
#(
    parameter int FRAMES = LRP_FRAMES_DEF,
    parameter int PAGES  = LRP_PAGES_DEF
)(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_W-1:0]          i_cfg_wdata,
    input  t_lrp_cmd                  i_cmd,
    input  logic [$clog2(PAGES)-1:0]  i_page,
    output t_lrp_sts                  o_sts,
    lrp_rsp_if.source                 o_rsp
);

    localparam int PAGE_W  = $clog2(PAGES);
    localparam int SLOT_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W  = SLOT_W;
    localparam int FILL_W  = $clog2(FRAMES + 1);
    localparam int WIN_RST = (int'(CFG_RESET) > FRAMES) ? FRAMES : int'(CFG_RESET);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(FRAMES - 1);

    // frame table
    logic [PAGE_W-1:0]  r_fpage [FRAMES];
    logic [RANK_W-1:0]  r_rank  [FRAMES];
    logic [FRAMES-1:0]  r_valid;
    logic [FILL_W-1:0]  r_filled;
    logic [FILL_W-1:0]  r_win;      // clamped frames_in_use
    logic [FAULT_W-1:0] r_faults;

    // item in flight
    logic [PAGE_W-1:0]  r_page;
    logic               r_hit;
    logic [SLOT_W-1:0]  r_tgt;
    logic [RANK_W-1:0]  r_ref_rank;
    logic               r_fill;
    logic               r_ev_valid;
    logic [PAGE_W-1:0]  r_ev_page;

    // result register
    logic               r_out_valid;
    logic               r_out_hit;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_ev_valid;
    logic [PAGE_W-1:0]  r_out_ev_page;
    logic [FAULT_W-1:0] r_out_faults;

    logic [FILL_W-1:0]  n_win;
    logic [FAULT_W-1:0] n_faults;

    logic               f_found;
    logic [SLOT_W-1:0]  f_hit_idx;
    logic               f_any;
    logic [RANK_W-1:0]  f_oldest;
    logic [SLOT_W-1:0]  f_vic;
    logic               f_fill_ok;
    logic [SLOT_W-1:0]  f_tgt;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_win = FILL_W'(1);
        end else if (int'(i_cfg_wdata) > FRAMES) begin
            n_win = FILL_W'(FRAMES);
        end else begin
            n_win = FILL_W'(i_cfg_wdata);
        end
    end

    // hit search, lowest index first; lru victim, lowest index on a tie
    always_comb begin
        f_found   = 1'b0;
        f_hit_idx = '0;
        f_any     = 1'b0;
        f_oldest  = '0;
        f_vic     = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (FILL_W'(i) < r_win && r_valid[i]) begin
                if (!f_found && r_fpage[i] == r_page) begin
                    f_found   = 1'b1;
                    f_hit_idx = SLOT_W'(i);
                end
                if (!f_any || r_rank[i] > f_oldest) begin
                    f_any    = 1'b1;
                    f_oldest = r_rank[i];
                    f_vic    = SLOT_W'(i);
                end
            end
        end
        f_fill_ok = r_filled < r_win;
        if (f_found) begin
            f_tgt = f_hit_idx;
        end else if (f_fill_ok) begin
            f_tgt = r_filled[SLOT_W-1:0];
        end else begin
            f_tgt = f_any ? f_vic : '0;
        end
    end

    assign n_faults = (r_faults == '1) ? r_faults : r_faults + FAULT_W'(1);

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_page <= i_page;
        end
        if (i_cmd.find) begin
            r_hit      <= f_found;
            r_tgt      <= f_tgt;
            r_ref_rank <= f_found ? r_rank[f_hit_idx] : RANK_MAX;
            r_fill     <= !f_found && f_fill_ok;
            r_ev_valid <= !f_found && r_valid[f_tgt];
            r_ev_page  <= (!f_found && r_valid[f_tgt]) ? r_fpage[f_tgt] : '0;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (SLOT_W'(i) == r_tgt) begin
                    r_rank[i] <= '0;
                    if (!r_hit) begin
                        r_fpage[i] <= r_page;
                    end
                end else if (r_valid[i] && r_rank[i] < r_ref_rank &&
                             r_rank[i] != RANK_MAX) begin
                    r_rank[i] <= r_rank[i] + RANK_W'(1);
                end
            end
            r_out_hit      <= r_hit;
            r_out_slot     <= r_tgt;
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_page  <= r_ev_page;
            r_out_faults   <= r_hit ? r_faults : n_faults;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_filled    <= '0;
            r_win       <= FILL_W'(WIN_RST);
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_win <= n_win;
            end
            if (i_cmd.commit && !r_hit) begin
                r_valid[r_tgt] <= 1'b1;
                r_faults       <= n_faults;
                if (r_fill) begin
                    r_filled <= r_filled + FILL_W'(1);
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_full  = r_out_valid;
    assign o_sts.out_taken = r_out_valid && o_rsp.ready;

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_out_hit;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.evicted_valid = r_out_ev_valid;
    assign o_rsp.evicted_page  = r_out_ev_page;
    assign o_rsp.fault_count   = r_out_faults;

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || o_rsp.ready))
        else $error("commit over an unread result");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result not shown after commit");

    a_faults_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_faults >= $past(r_faults))
        else $error("fault count went backward");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_fill |-> r_filled < r_win)
        else $error("fill past the window");
`endif

endmodule

### sim/tb_lru_page_replacement.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement;
    import lrp_pkg::*;

    localparam int FRAMES        = LRP_FRAMES_DEF;
    localparam int PAGES         = LRP_PAGES_DEF;
    localparam int PAGE_W        = 4;
    localparam int SLOT_W        = 3;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_REFS    = 112;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_count;
    } t_outcome;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    lrp_req_if #(.PAGE_W(PAGE_W)) ref_if ();
    lrp_rsp_if #(.PAGE_W(PAGE_W), .SLOT_W(SLOT_W), .FAULT_W(FAULT_W)) out_if ();

    lru_page_replacement #(
        .FRAMES(FRAMES),
        .PAGES (PAGES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (ref_if),
        .o_rsp      (out_if)
    );

    // mirror of the frame table
    logic [PAGE_W-1:0]  frame_page [FRAMES];
    bit                 frame_used [FRAMES];
    logic [SLOT_W-1:0]  frame_age  [FRAMES];
    int                 frames_filled;
    logic [FAULT_W-1:0] faults_seen;
    logic [CFG_W-1:0]   frames_cfg;

    logic [PAGE_W-1:0] page_refs_q [$];
    t_outcome          outcome_q [$];

    int send_idle_pct;
    int stall_pct;
    bit ref_taken;
    int error_cnt;
    int results_seen;
    int cycle_cnt;

    function automatic int window_size();
        if (frames_cfg == 0)
            return 1;
        if (frames_cfg > FRAMES)
            return FRAMES;
        return int'(frames_cfg);
    endfunction

    // target frame becomes youngest, younger valid frames age by one
    function automatic void refresh_ages(input int tgt, input int old_age);
        for (int i = 0; i < FRAMES; i++) begin
            if (i != tgt && frame_used[i] && frame_age[i] < old_age && frame_age[i] < FRAMES - 1)
                frame_age[i]++;
        end
        frame_age[tgt] = '0;
    endfunction

    function automatic t_outcome predict_reference(input logic [PAGE_W-1:0] page);
        t_outcome          res;
        int                win;
        int                tgt;
        bit                found;
        bit                any;
        logic [SLOT_W-1:0] oldest;
        res    = '0;
        win    = window_size();
        tgt    = 0;
        found  = 0;
        any    = 0;
        oldest = '0;
        // lowest matching index wins when a page sits in two frames
        for (int i = 0; i < win; i++) begin
            if (!found && frame_used[i] && frame_page[i] == page) begin
                tgt   = i;
                found = 1;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            refresh_ages(tgt, int'(frame_age[tgt]));
        end else begin
            if (frames_filled < win) begin
                tgt = frames_filled;
                frames_filled++;
            end else begin
                for (int i = 0; i < win; i++) begin
                    if (frame_used[i] && (!any || frame_age[i] > oldest)) begin
                        oldest = frame_age[i];
                        tgt    = i;
                        any    = 1;
                    end
                end
                if (!any)
                    tgt = 0;
            end
            if (frame_used[tgt]) begin
                res.evicted_valid = 1'b1;
                res.evicted_page  = frame_page[tgt];
            end
            frame_page[tgt] = page;
            frame_used[tgt] = 1;
            refresh_ages(tgt, FRAMES - 1);
            if (faults_seen != '1)
                faults_seen++;
        end
        res.slot        = SLOT_W'(tgt);
        res.fault_count = faults_seen;
        return res;
    endfunction

    task automatic write_frames(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        frames_cfg   = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every reference is in and answered, then let the pipe settle
    task automatic drain_block();
        do
            @(posedge i_clk);
        while (page_refs_q.size() != 0 || ref_if.valid || outcome_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // reference driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!ref_if.valid || ref_taken)) begin
            if (page_refs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                ref_if.valid <= 1'b1;
                ref_if.page  <= page_refs_q.pop_front();
            end else begin
                ref_if.valid <= 1'b0;
                ref_if.page  <= PAGE_W'($urandom);
            end
        end
    end

    always @(negedge i_clk)
        out_if.ready <= ($urandom_range(99) >= stall_pct);

    // predict on acceptance, check each result against the oldest outcome
    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        ref_taken <= i_rst_n && ref_if.valid && ref_if.ready;
        if (i_rst_n && ref_if.valid && ref_if.ready)
            outcome_q.push_back(predict_reference(ref_if.page));
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.hit, out_if.slot, out_if.evicted_valid,
                    out_if.evicted_page, out_if.fault_count};
            if (outcome_q.size() == 0) begin
                error_cnt++;
                if (error_cnt <= MAX_REPORTS)
                    $display("result %0d arrived with no reference pending", results_seen);
            end else begin
                want = outcome_q.pop_front();
                if (got !== want) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS) begin
                        $display("result %0d: expected hit %0b slot %0d evict %0b/%0d faults %0d",
                                 results_seen, want.hit, want.slot, want.evicted_valid,
                                 want.evicted_page, want.fault_count);
                        $display("    actual hit %0b slot %0d evict %0b/%0d faults %0d",
                                 got.hit, got.slot, got.evicted_valid,
                                 got.evicted_page, got.fault_count);
                    end
                end
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // idle percentages per mode: none, sender, receiver, both
        int send_by_mode [4];
        int stall_by_mode [4];
        int phase_cfg [RANDOM_PHASES];
        int base;
        int span;
        logic [PAGE_W-1:0] pg;
        send_by_mode  = '{0, 65, 0, 37};
        stall_by_mode = '{0, 0, 65, 37};
        phase_cfg     = '{8, 1, 0, 15, 4, 2, 7, 3, 12, 5, 6, 9};

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        ref_if.valid  = 1'b0;
        ref_if.page   = '0;
        out_if.ready  = 1'b0;
        ref_taken     = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        error_cnt     = 0;
        results_seen  = 0;
        cycle_cnt     = 0;
        frames_filled = 0;
        faults_seen   = '0;
        frames_cfg    = CFG_RESET;
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_used[i] = 0;
            frame_age[i]  = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill a small window, hit, then evict the oldest
        write_frames(CFG_W'(3));
        page_refs_q = '{4'd0, 4'd1, 4'd2, 4'd1, 4'd5, 4'd15};
        drain_block();

        // window above the frame count acts as all frames: fill the rest
        write_frames(CFG_W'(15));
        page_refs_q = '{4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd12, 4'd15};
        drain_block();

        // shrunk window: page 9 sits outside it, so it faults into the window
        write_frames(CFG_W'(2));
        page_refs_q = '{4'd4, 4'd9};
        drain_block();

        // grown again: page 9 now resident twice
        write_frames(CFG_W'(8));
        page_refs_q = '{4'd9, 4'd7};
        drain_block();

        // zero window acts as one frame
        write_frames(CFG_W'(0));
        page_refs_q = '{4'd0, 4'd0, 4'd3};
        drain_block();

        // random phases: mostly a drifting working set near the window size
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_frames(CFG_W'(phase_cfg[p]));
            send_idle_pct = send_by_mode[p % 4];
            stall_pct     = stall_by_mode[p % 4];
            span          = window_size() + 2;
            base          = $urandom_range(PAGES - 1);
            for (int k = 0; k < PHASE_REFS; k++) begin
                if ($urandom_range(9) == 0)
                    base = $urandom_range(PAGES - 1);
                if ($urandom_range(99) < 20)
                    pg = PAGE_W'($urandom_range(PAGES - 1));
                else
                    pg = PAGE_W'(base + $urandom_range(span));
                page_refs_q.push_back(pg);
            end
            drain_block();
        end

        if (error_cnt == 0 && outcome_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
